// ----- design/sesd_pkg.sv -----
// ----------------------------------------------------------------------------
// Song event stream decoder package
// Shared types and constants for the song event stream decoder.
// ----------------------------------------------------------------------------
package sesd_pkg;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int CHAN_W     = 3;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int DUR_W      = 19;
   localparam int FINE_W     = 14;
   localparam int COARSE_W   = 7;
   localparam int DELAY_W    = 15;
   localparam int POS_W      = 16;
   localparam int RATE_W     = 16;
   localparam int MS_W       = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd11290;
   localparam logic [DELAY_W-1:0] DELAY_MAX = 15'h7fff;
   localparam logic [DUR_W-1:0]   DUR_MAX   = 19'h7ffff;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DELAY   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WHEEL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_END     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_POSITION = 2'd2;

   typedef enum logic [1:0] {
      STG_LEAD,
      STG_NOTE_FIRST,
      STG_NOTE_SECOND,
      STG_SINGLE
   } stage_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_data;
      logic              skip;
   } item_type;

   typedef struct packed {
      stage_type         stage;
      logic              skipping;
      logic [BYTE_W-1:0] held_lead;
      logic [BYTE_W-1:0] held_first;
   } parse_type;

   typedef struct packed {
      logic [RATE_W-1:0] frame_rate;
      logic              repeat_enable;
      logic [POS_W-1:0]  loop_position;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CHAN_W-1:0]   channel;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
      logic [DUR_W-1:0]    duration_frames;
      logic [FINE_W-1:0]   wheel_fine;
      logic [COARSE_W-1:0] wheel_coarse;
      logic [DELAY_W-1:0]  delay_frames;
      logic [POS_W-1:0]    resume_at;
   } result_type;

endpackage

// ----- design/sesd_if.sv -----
// ----------------------------------------------------------------------------
// Song event stream decoder channels
// Valid/ready channels for the byte input and the decoded result output.
// ----------------------------------------------------------------------------
interface sesd_req_if;
   logic                          valid;
   logic                          ready;
   logic [sesd_pkg::BYTE_W-1:0]   data_byte;
   logic                          end_of_data;
   logic                          skip;

   modport source (output valid, output data_byte, output end_of_data, output skip,
                   input ready);
   modport sink   (input valid, input data_byte, input end_of_data, input skip,
                   output ready);
endinterface

interface sesd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sesd_pkg::KIND_W-1:0]     kind;
   logic [sesd_pkg::CHAN_W-1:0]     channel;
   logic [sesd_pkg::NOTE_W-1:0]     note;
   logic [sesd_pkg::VEL_W-1:0]      velocity;
   logic [sesd_pkg::DUR_W-1:0]      duration_frames;
   logic [sesd_pkg::FINE_W-1:0]     wheel_fine;
   logic [sesd_pkg::COARSE_W-1:0]   wheel_coarse;
   logic [sesd_pkg::DELAY_W-1:0]    delay_frames;
   logic [sesd_pkg::POS_W-1:0]      resume_at;

   modport source (output valid, output kind, output channel, output note,
                   output velocity, output duration_frames, output wheel_fine,
                   output wheel_coarse, output delay_frames, output resume_at,
                   input ready);
   modport sink   (input valid, input kind, input channel, input note,
                   input velocity, input duration_frames, input wheel_fine,
                   input wheel_coarse, input delay_frames, input resume_at,
                   output ready);
endinterface

// ----- design/sesd_decode.sv -----
// ----------------------------------------------------------------------------
// Song event stream decoder: byte decode
// Combinational decode of one byte against the parser state, with the
// millisecond to frame conversion through one shared multiplier.
// ----------------------------------------------------------------------------
module sesd_decode #(
   parameter int RATE_FRAC_BITS = 8
) (
   input  sesd_pkg::item_type   item,
   input  sesd_pkg::parse_type  parse,
   input  sesd_pkg::cfg_type    cfg,
   output sesd_pkg::parse_type  parse_next,
   output logic                 emit,
   output sesd_pkg::result_type result
);

   localparam int SUM_W = sesd_pkg::MS_W + sesd_pkg::RATE_W + 1;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (RATE_FRAC_BITS - 1);

   logic [sesd_pkg::BYTE_W-1:0] b;
   logic [sesd_pkg::BYTE_W-1:0] lead;
   logic [sesd_pkg::MS_W-1:0]   ms_op;
   logic [SUM_W-1:0]            prod_sum;
   logic [SUM_W-1:0]            frames_full;
   logic [sesd_pkg::DELAY_W-1:0] delay_sat;
   logic [sesd_pkg::DUR_W-1:0]   dur_sat;

   assign b    = item.data_byte;
   assign lead = parse.held_lead;

   // A delay lead carries milliseconds directly; a note's second byte
   // carries duration in units of 32 ms.
   assign ms_op = (parse.stage == sesd_pkg::STG_LEAD) ?
                  {4'b0, b[6:0]} : {b[5:0], 5'b0};

   assign prod_sum    = SUM_W'(ms_op) * SUM_W'(cfg.frame_rate) + HALF;
   assign frames_full = prod_sum >> RATE_FRAC_BITS;

   always_comb begin
      if (frames_full > SUM_W'(sesd_pkg::DELAY_MAX)) begin
         delay_sat = sesd_pkg::DELAY_MAX;
      end else if (frames_full == '0) begin
         delay_sat = sesd_pkg::DELAY_W'(1);
      end else begin
         delay_sat = frames_full[sesd_pkg::DELAY_W-1:0];
      end
      if (frames_full > SUM_W'(sesd_pkg::DUR_MAX)) begin
         dur_sat = sesd_pkg::DUR_MAX;
      end else begin
         dur_sat = frames_full[sesd_pkg::DUR_W-1:0];
      end
   end

   always_comb begin
      parse_next = parse;
      emit       = 1'b0;
      result     = '0;

      unique case (parse.stage)
         sesd_pkg::STG_LEAD: begin
            parse_next.stage    = sesd_pkg::STG_LEAD;
            parse_next.skipping = 1'b0;
            emit                = 1'b1;
            if (item.end_of_data || b == '0) begin
               if (cfg.repeat_enable) begin
                  result.kind         = sesd_pkg::KIND_RESTART;
                  result.delay_frames = sesd_pkg::DELAY_W'(1);
                  result.resume_at    = cfg.loop_position;
               end else begin
                  result.kind = sesd_pkg::KIND_END;
               end
            end else if (!b[7]) begin
               result.kind         = sesd_pkg::KIND_DELAY;
               result.delay_frames = delay_sat;
            end else if (b[7:4] == 4'h8) begin
               emit                 = 1'b0;
               parse_next.stage     = sesd_pkg::STG_NOTE_FIRST;
               parse_next.skipping  = item.skip;
               parse_next.held_lead = b;
            end else if (b[7:4] == 4'h9 || b[7:3] == 5'h14) begin
               emit                 = 1'b0;
               parse_next.stage     = sesd_pkg::STG_SINGLE;
               parse_next.skipping  = item.skip;
               parse_next.held_lead = b;
            end else begin
               result.kind = sesd_pkg::KIND_ERROR;
            end
         end

         sesd_pkg::STG_NOTE_FIRST: begin
            if (item.end_of_data) begin
               parse_next.stage    = sesd_pkg::STG_LEAD;
               parse_next.skipping = 1'b0;
               emit                = 1'b1;
               result.kind         = sesd_pkg::KIND_ERROR;
            end else begin
               parse_next.stage      = sesd_pkg::STG_NOTE_SECOND;
               parse_next.held_first = b;
            end
         end

         sesd_pkg::STG_NOTE_SECOND: begin
            parse_next.stage    = sesd_pkg::STG_LEAD;
            parse_next.skipping = 1'b0;
            if (item.end_of_data) begin
               emit        = 1'b1;
               result.kind = sesd_pkg::KIND_ERROR;
            end else if (!parse.skipping) begin
               emit                   = 1'b1;
               result.kind            = sesd_pkg::KIND_NOTE;
               result.channel         = parse.held_first[7:5];
               result.note            = {parse.held_first[4:0], b[7:6]};
               result.velocity        = {lead[3:0], lead[3:1]};
               result.duration_frames = dur_sat;
            end
         end

         sesd_pkg::STG_SINGLE: begin
            parse_next.stage    = sesd_pkg::STG_LEAD;
            parse_next.skipping = 1'b0;
            if (item.end_of_data) begin
               emit        = 1'b1;
               result.kind = sesd_pkg::KIND_ERROR;
            end else if (!parse.skipping) begin
               emit = 1'b1;
               if (lead[7:4] == 4'h9) begin
                  // Fire-and-forget: two velocity bits replicated three times below a zero top bit.
                  result.kind     = sesd_pkg::KIND_NOTE;
                  result.channel  = {lead[1:0], b[7]};
                  result.note     = b[6:0];
                  result.velocity = {1'b0, lead[3:2], lead[3:2], lead[3:2]};
               end else begin
                  result.kind         = sesd_pkg::KIND_WHEEL;
                  result.channel      = lead[2:0];
                  result.wheel_fine   = {b, 6'b0};
                  result.wheel_coarse = b[7:1];
               end
            end
         end
      endcase
   end

endmodule

// ----- design/song_event_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// Song event stream decoder
// Decodes song body bytes into delay, note, wheel, end, restart and error
// results.
// ----------------------------------------------------------------------------
// One byte (or end-of-data marker) is taken per clock. A transfer on the
// request channel lands in an input register; from there the byte is
// decoded against the parser state and any result is written to the output
// register once that register is free or drains. The block sustains one
// byte per cycle while the result channel keeps up. The single 11x16
// multiplier that turns milliseconds into frames works in the decode
// cycle. Bytes that only open or extend an event, and bytes of
// skipped events, give no result. Configuration writes are taken at any time
// and must only be issued while the block is idle.
module song_event_stream_decoder #(
   parameter int RATE_FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   sesd_req_if.sink                           req_ch,
   sesd_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [sesd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sesd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                 in_valid_ff;
   sesd_pkg::item_type   in_item_ff;
   sesd_pkg::parse_type  parse_ff;
   sesd_pkg::parse_type  parse_in;
   sesd_pkg::cfg_type    cfg_ff;
   logic                 out_valid_ff;
   sesd_pkg::result_type out_res_ff;

   logic                 advance;
   logic                 dec_emit;
   sesd_pkg::result_type dec_result;
   sesd_pkg::item_type   req_item;

   // The held item moves on when the output register is free or drains now.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign req_item.data_byte   = req_ch.data_byte;
   assign req_item.end_of_data = req_ch.end_of_data;
   assign req_item.skip        = req_ch.skip;

   sesd_decode #(
      .RATE_FRAC_BITS (RATE_FRAC_BITS)
   ) u_decode (
      .item       (in_item_ff),
      .parse      (parse_ff),
      .cfg        (cfg_ff),
      .parse_next (parse_in),
      .emit       (dec_emit),
      .result     (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= '0;
      end else if (advance) begin
         parse_ff <= parse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dec_emit;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && dec_emit) begin
         out_res_ff <= dec_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_rate    <= sesd_pkg::RATE_RESET;
         cfg_ff.repeat_enable <= 1'b0;
         cfg_ff.loop_position <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sesd_pkg::CSR_FRAME_RATE:    cfg_ff.frame_rate    <= csr_wdata;
            sesd_pkg::CSR_REPEAT_ENABLE: cfg_ff.repeat_enable <= csr_wdata[0];
            sesd_pkg::CSR_LOOP_POSITION: cfg_ff.loop_position <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.kind            = out_res_ff.kind;
   assign rsp_ch.channel         = out_res_ff.channel;
   assign rsp_ch.note            = out_res_ff.note;
   assign rsp_ch.velocity        = out_res_ff.velocity;
   assign rsp_ch.duration_frames = out_res_ff.duration_frames;
   assign rsp_ch.wheel_fine      = out_res_ff.wheel_fine;
   assign rsp_ch.wheel_coarse    = out_res_ff.wheel_coarse;
   assign rsp_ch.delay_frames    = out_res_ff.delay_frames;
   assign rsp_ch.resume_at       = out_res_ff.resume_at;

endmodule

// ----- tb/song_event_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Song event stream decoder testbench
// Drives song body bytes and end-of-data markers through the request channel,
// predicts each decoded event from a behavioral copy of the parser, and checks
// every result transfer field by field while both channels idle at random.
// ----------------------------------------------------------------------------
module song_event_stream_decoder_tb;

   localparam int FRAC_BITS     = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_IDLE      = 13;
   localparam int PHASE_ITEMS   = 290;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [sesd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sesd_pkg::CSR_DATA_W-1:0] csr_wdata;

   sesd_req_if req_ch ();
   sesd_rsp_if rsp_ch ();

   song_event_stream_decoder #(
      .RATE_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Stimulus and expectations.
   sesd_pkg::item_type   pending_bytes[$];
   sesd_pkg::result_type expected_events[$];
   int                   items_queued;
   int                   fail_count;

   // Behavioral copy of the parser and its registers.
   sesd_pkg::stage_type           parse_stage;
   logic                          parse_skipping;
   logic [sesd_pkg::BYTE_W-1:0]   lead_byte;
   logic [sesd_pkg::BYTE_W-1:0]   first_byte;
   logic [sesd_pkg::RATE_W-1:0]   rate_q8;
   logic                          repeat_on;
   logic [sesd_pkg::POS_W-1:0]    loop_pos;

   // Handshake bookkeeping.
   logic req_fire;
   logic rsp_fire;
   int   req_wait;
   int   rsp_wait;
   bit   req_burst;
   bit   rsp_burst;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("song_event_stream_decoder test failed");
      $finish;
   end

   function automatic logic [31:0] ms_to_frames(input logic [sesd_pkg::MS_W-1:0] ms);
      logic [31:0] scaled;
      scaled = 32'(ms) * 32'(rate_q8) + 32'(1 << (FRAC_BITS - 1));
      return scaled >> FRAC_BITS;
   endfunction

   // Most draws idle for a random count; now and then a side switches into a
   // stretch where it never idles.
   function automatic int idle_draw(inout bit burst);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      return burst ? 0 : int'($urandom_range(0, MAX_IDLE));
   endfunction

   task automatic decode_transfer(input sesd_pkg::item_type it);
      sesd_pkg::result_type        r;
      logic                        emit;
      logic [31:0]                 frames;
      logic [sesd_pkg::VEL_W-1:0]  vel;
      logic [sesd_pkg::MS_W-1:0]   ms;
      sesd_pkg::stage_type         stage_now;
      r = '0;
      emit = 1'b0;
      stage_now = parse_stage;
      if (stage_now == sesd_pkg::STG_LEAD) begin
         parse_skipping = 1'b0;
         if (it.end_of_data || it.data_byte == 8'h00) begin
            emit = 1'b1;
            if (repeat_on) begin
               r.kind = sesd_pkg::KIND_RESTART;
               r.delay_frames = sesd_pkg::DELAY_W'(1);
               r.resume_at = loop_pos;
            end else begin
               r.kind = sesd_pkg::KIND_END;
            end
         end else if (!it.data_byte[7]) begin
            ms = {4'b0, it.data_byte[6:0]};
            frames = ms_to_frames(ms);
            emit = 1'b1;
            r.kind = sesd_pkg::KIND_DELAY;
            if (frames == 0) r.delay_frames = sesd_pkg::DELAY_W'(1);
            else if (frames > 32'(sesd_pkg::DELAY_MAX)) r.delay_frames = sesd_pkg::DELAY_MAX;
            else r.delay_frames = frames[sesd_pkg::DELAY_W-1:0];
         end else if (it.data_byte[7:4] == 4'h8 || it.data_byte[7:4] == 4'h9 ||
                      it.data_byte[7:3] == 5'b10100) begin
            lead_byte = it.data_byte;
            parse_skipping = it.skip;
            parse_stage = (it.data_byte[7:4] == 4'h8) ? sesd_pkg::STG_NOTE_FIRST
                                                      : sesd_pkg::STG_SINGLE;
         end else begin
            emit = 1'b1;
            r.kind = sesd_pkg::KIND_ERROR;
         end
      end else if (it.end_of_data) begin
         // The open event is dropped.
         parse_stage = sesd_pkg::STG_LEAD;
         parse_skipping = 1'b0;
         emit = 1'b1;
         r.kind = sesd_pkg::KIND_ERROR;
      end else if (stage_now == sesd_pkg::STG_NOTE_FIRST) begin
         first_byte = it.data_byte;
         parse_stage = sesd_pkg::STG_NOTE_SECOND;
      end else begin
         parse_stage = sesd_pkg::STG_LEAD;
         if (!parse_skipping) begin
            emit = 1'b1;
            if (stage_now == sesd_pkg::STG_NOTE_SECOND) begin
               vel = {lead_byte[3:0], 3'b000};
               vel = vel | (vel >> 4);
               ms = {it.data_byte[5:0], 5'b00000};
               frames = ms_to_frames(ms);
               r.kind = sesd_pkg::KIND_NOTE;
               r.channel = first_byte[7:5];
               r.note = {first_byte[4:0], it.data_byte[7:6]};
               r.velocity = vel;
               r.duration_frames = (frames > 32'(sesd_pkg::DUR_MAX)) ?
                                   sesd_pkg::DUR_MAX : frames[sesd_pkg::DUR_W-1:0];
            end else if (lead_byte[7:4] == 4'h9) begin
               vel = {1'b0, lead_byte[3:2], 4'b0000};
               vel = vel | (vel >> 2);
               vel = vel | (vel >> 4);
               r.kind = sesd_pkg::KIND_NOTE;
               r.channel = {lead_byte[1:0], it.data_byte[7]};
               r.note = it.data_byte[6:0];
               r.velocity = vel;
            end else begin
               r.kind = sesd_pkg::KIND_WHEEL;
               r.channel = lead_byte[2:0];
               r.wheel_fine = {it.data_byte, 6'b000000};
               r.wheel_coarse = it.data_byte[7:1];
            end
         end
         parse_skipping = 1'b0;
      end
      if (emit) expected_events.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endtask

   task automatic check_result();
      sesd_pkg::result_type want;
      if (expected_events.size() == 0) begin
         fail_count++;
         $error("result transfer with no expectation waiting: kind %0d", rsp_ch.kind);
      end else begin
         want = expected_events.pop_front();
         check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
         check_field("channel", 32'(want.channel), 32'(rsp_ch.channel));
         check_field("note", 32'(want.note), 32'(rsp_ch.note));
         check_field("velocity", 32'(want.velocity), 32'(rsp_ch.velocity));
         check_field("duration_frames", 32'(want.duration_frames),
                     32'(rsp_ch.duration_frames));
         check_field("wheel_fine", 32'(want.wheel_fine), 32'(rsp_ch.wheel_fine));
         check_field("wheel_coarse", 32'(want.wheel_coarse), 32'(rsp_ch.wheel_coarse));
         check_field("delay_frames", 32'(want.delay_frames), 32'(rsp_ch.delay_frames));
         check_field("resume_at", 32'(want.resume_at), 32'(rsp_ch.resume_at));
      end
   endtask

   // Monitor: both channels are sampled at the rising edge.
   always @(posedge clock) begin
      sesd_pkg::item_type seen;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         rsp_fire <= rsp_ch.valid && rsp_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen.data_byte = req_ch.data_byte;
            seen.end_of_data = req_ch.end_of_data;
            seen.skip = req_ch.skip;
            decode_transfer(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) check_result();
      end
   end

   // Byte driver: a new item goes out only once the current one has transferred
   // and the idle count drawn after it has run down.
   always @(negedge clock) begin
      sesd_pkg::item_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_wait = 0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_ch.valid) req_wait = idle_draw(req_burst);
         if (req_wait > 0) begin
            req_wait--;
            req_ch.valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_item = pending_bytes.pop_front();
            req_ch.data_byte <= next_item.data_byte;
            req_ch.end_of_data <= next_item.end_of_data;
            req_ch.skip <= next_item.skip;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls for a drawn count after every transfer.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_fire) rsp_wait = idle_draw(rsp_burst);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic queue_item(input logic [sesd_pkg::BYTE_W-1:0] b, input logic eod,
                             input logic sk);
      sesd_pkg::item_type it;
      it.data_byte = b;
      it.end_of_data = eod;
      it.skip = sk;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   task automatic queue_data(input logic [sesd_pkg::BYTE_W-1:0] b);
      queue_item(b, 1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic queue_event();
      int                          pick;
      logic                        sk;
      pick = $urandom_range(0, 99);
      sk = ($urandom_range(0, 4) == 0);
      if (pick < 18) begin
         queue_item(8'($urandom_range(1, 127)), 1'b0, sk);
      end else if (pick < 40) begin
         queue_item(8'h80 | 8'($urandom_range(0, 15)), 1'b0, sk);
         queue_data(8'($urandom));
         queue_data(8'($urandom));
      end else if (pick < 56) begin
         queue_item(8'h90 | 8'($urandom_range(0, 15)), 1'b0, sk);
         queue_data(8'($urandom));
      end else if (pick < 70) begin
         queue_item(8'ha0 | 8'($urandom_range(0, 7)), 1'b0, sk);
         queue_data(8'($urandom));
      end else if (pick < 78) begin
         if ($urandom_range(0, 1) == 0) queue_item(8'h00, 1'b0, sk);
         else queue_item(8'($urandom), 1'b1, sk);
      end else if (pick < 86) begin
         // Every lead from 0xa8 upward is reserved.
         queue_item(8'($urandom_range(8'ha8, 8'hff)), 1'b0, sk);
      end else if (pick < 94) begin
         // An event cut short by end of data.
         case ($urandom_range(0, 2))
            0: begin
               queue_item(8'h80 | 8'($urandom_range(0, 15)), 1'b0, sk);
               if ($urandom_range(0, 1) == 1) queue_data(8'($urandom));
            end
            1: queue_item(8'h90 | 8'($urandom_range(0, 15)), 1'b0, sk);
            default: queue_item(8'ha0 | 8'($urandom_range(0, 7)), 1'b0, sk);
         endcase
         queue_item(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
      end else begin
         queue_data(8'($urandom));
      end
   endtask

   task automatic random_phase();
      int start;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) queue_event();
   endtask

   // Sampled at the rising edge, where the byte channel is stable and no new
   // expectation can be pending from an unseen transfer.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sesd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sesd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         sesd_pkg::CSR_FRAME_RATE:    rate_q8 = value;
         sesd_pkg::CSR_REPEAT_ENABLE: repeat_on = value[0];
         sesd_pkg::CSR_LOOP_POSITION: loop_pos = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [sesd_pkg::RATE_W-1:0] rate, input logic rep,
                            input logic [sesd_pkg::POS_W-1:0] pos);
      write_reg(sesd_pkg::CSR_FRAME_RATE, rate);
      write_reg(sesd_pkg::CSR_REPEAT_ENABLE, sesd_pkg::CSR_DATA_W'(rep));
      write_reg(sesd_pkg::CSR_LOOP_POSITION, pos);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.end_of_data = 1'b0;
      req_ch.skip = 1'b0;
      rsp_ch.ready = 1'b0;
      items_queued = 0;
      fail_count = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      parse_stage = sesd_pkg::STG_LEAD;
      parse_skipping = 1'b0;
      lead_byte = '0;
      first_byte = '0;
      rate_q8 = sesd_pkg::RATE_RESET;
      repeat_on = 1'b0;
      loop_pos = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: end markers, delay extremes, each event type at its field
      // extremes, reserved leads, end of data inside events, skipped events.
      queue_item(8'h00, 1'b0, 1'b0);
      queue_item(8'h5a, 1'b1, 1'b0);
      queue_item(8'h01, 1'b0, 1'b0);
      queue_item(8'h7f, 1'b0, 1'b0);
      queue_item(8'h8f, 1'b0, 1'b0);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h80, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b0);
      queue_item(8'h9c, 1'b0, 1'b0);
      queue_item(8'h80, 1'b0, 1'b0);
      queue_item(8'ha7, 1'b0, 1'b0);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'ha8, 1'b0, 1'b0);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h85, 1'b0, 1'b0);
      queue_item(8'ha5, 1'b1, 1'b0);
      queue_item(8'h86, 1'b0, 1'b0);
      queue_item(8'h12, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);
      queue_item(8'ha2, 1'b0, 1'b1);
      queue_item(8'h33, 1'b0, 1'b0);
      queue_item(8'h8a, 1'b0, 1'b1);
      queue_item(8'h11, 1'b0, 1'b0);
      queue_item(8'h22, 1'b0, 1'b1);
      random_phase();

      wait_for_idle();
      configure(16'd1, 1'b1, 16'hffff);
      random_phase();

      wait_for_idle();
      configure(16'hffff, 1'b0, 16'h0000);
      random_phase();

      wait_for_idle();
      configure(16'($urandom_range(1, 65535)), 1'b1, 16'($urandom));
      random_phase();

      wait_for_idle();
      configure(16'd256, 1'b1, 16'h0000);
      random_phase();

      wait_for_idle();
      configure(16'($urandom_range(1, 300)), 1'b0, 16'($urandom));
      random_phase();

      wait_for_idle();
      if (fail_count == 0) begin
         $display("song_event_stream_decoder test passed");
      end else begin
         $display("song_event_stream_decoder test failed");
      end
      $finish;
   end

endmodule
